@@ rtl/core/quadratic_root_solver_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the quadratic root solver
// Shared checks, written against the clk and arst_n of the asserting module.
// ----------------------------------------------------------------------------
`ifndef QUADRATIC_ROOT_SOLVER_DEFINES_SVH
`define QUADRATIC_ROOT_SOLVER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define QRS_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("quadratic_root_solver: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define QRS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("quadratic_root_solver: assertion failed");

`endif

@@ rtl/core/qrs_pkg.sv @@
// ----------------------------------------------------------------------------
// qrs_pkg
// Widths, class codes and pipeline payload types of the quadratic root solver.
// ----------------------------------------------------------------------------
package qrs_pkg;

	// Field widths.
	localparam int COEFF_WIDTH   = 16;
	localparam int COEFF_FRAC    = 8;
	localparam int FRAC_BITS_OUT = 16;
	localparam int ROOT_WIDTH    = 40;
	localparam int CLASS_WIDTH   = 3;

	// Discriminant and square root sizes.
	localparam int PROD_W     = 2 * COEFF_WIDTH;
	localparam int DELTA_W    = PROD_W + 2;
	localparam int RAD_SHIFT  = 2 * FRAC_BITS_OUT - 2 * COEFF_FRAC;
	localparam int SQ_STAGES  = (DELTA_W - 1 + RAD_SHIFT + 1) / 2;
	localparam int RAD_W      = 2 * SQ_STAGES;
	localparam int REM_W      = SQ_STAGES + 3;

	// Divider sizes: numerators stay below 2^34, divisors at most 2^16.
	localparam int NUM_W      = 35;
	localparam int DSR_W      = COEFF_WIDTH + 1;
	localparam int DIV_STAGES = NUM_W;

	// Root classes.
	localparam logic [CLASS_WIDTH-1:0] CLS_LINEAR = 3'd0;
	localparam logic [CLASS_WIDTH-1:0] CLS_DOUBLE = 3'd1;
	localparam logic [CLASS_WIDTH-1:0] CLS_TWO    = 3'd2;
	localparam logic [CLASS_WIDTH-1:0] CLS_NONE   = 3'd3;
	localparam logic [CLASS_WIDTH-1:0] CLS_DEGEN  = 3'd4;

	// One step of the digit-by-digit square root.
	typedef struct packed {
		logic [RAD_W-1:0]     rad;
		logic [REM_W-1:0]     rem;
		logic [SQ_STAGES-1:0] root;
	} sqrt_t;

	// One step of the restoring divider.
	typedef struct packed {
		logic [NUM_W-1:0] dvd;
		logic [DSR_W-1:0] dsr;
		logic [DSR_W-1:0] rem;
		logic [NUM_W-1:0] quo;
	} divw_t;

	// Sideband that travels with each word.
	typedef struct packed {
		logic [CLASS_WIDTH-1:0]  cls;
		logic [COEFF_WIDTH-1:0]  a;
		logic [COEFF_WIDTH-1:0]  b;
		logic [COEFF_WIDTH-1:0]  c;
		logic                    neg1;
		logic                    neg2;
	} side_t;

endpackage

@@ rtl/core/qrs_sqrt_stage.sv @@
// ----------------------------------------------------------------------------
// qrs_sqrt_stage
// One registered step of the square root: settles one root bit per stage.
// ----------------------------------------------------------------------------
module qrs_sqrt_stage (
	input  logic           clk,
	input  logic           en,
	input  qrs_pkg::sqrt_t d,
	output qrs_pkg::sqrt_t q
);
	import qrs_pkg::*;

	logic [REM_W-1:0] cur;
	logic [REM_W-1:0] trial;
	sqrt_t            nxt;

	// Bring down two radicand bits and try the next root bit.
	always_comb begin
		cur   = {d.rem[REM_W-3:0], d.rad[RAD_W-1 -: 2]};
		trial = {1'b0, d.root, 2'b01};
		nxt.rad = {d.rad[RAD_W-3:0], 2'b00};
		if (cur >= trial) begin
			nxt.rem  = cur - trial;
			nxt.root = {d.root[SQ_STAGES-2:0], 1'b1};
		end else begin
			nxt.rem  = cur;
			nxt.root = {d.root[SQ_STAGES-2:0], 1'b0};
		end
	end

	// Stage register.
	always_ff @(posedge clk) begin
		if (en) begin
			q <= nxt;
		end
	end

endmodule

@@ rtl/core/qrs_div_stage.sv @@
// ----------------------------------------------------------------------------
// qrs_div_stage
// One registered step of the restoring divider: one quotient bit per stage.
// ----------------------------------------------------------------------------
module qrs_div_stage (
	input  logic           clk,
	input  logic           en,
	input  qrs_pkg::divw_t d,
	output qrs_pkg::divw_t q
);
	import qrs_pkg::*;

	logic [DSR_W:0] cur;
	logic [DSR_W:0] diff;
	divw_t          nxt;

	// Shift in the next dividend bit and subtract the divisor if it fits.
	always_comb begin
		cur     = {d.rem, d.dvd[NUM_W-1]};
		diff    = cur - {1'b0, d.dsr};
		nxt.dvd = {d.dvd[NUM_W-2:0], 1'b0};
		nxt.dsr = d.dsr;
		if (cur >= {1'b0, d.dsr}) begin
			nxt.rem = diff[DSR_W-1:0];
			nxt.quo = {d.quo[NUM_W-2:0], 1'b1};
		end else begin
			nxt.rem = cur[DSR_W-1:0];
			nxt.quo = {d.quo[NUM_W-2:0], 1'b0};
		end
	end

	// Stage register.
	always_ff @(posedge clk) begin
		if (en) begin
			q <= nxt;
		end
	end

endmodule

@@ rtl/core/quadratic_root_solver.sv @@
// ----------------------------------------------------------------------------
// quadratic_root_solver
// Real roots of a*x^2 + b*x + c = 0 from Q8.8 coefficients, in Q24.16.
// ----------------------------------------------------------------------------
// The solver takes one coefficient word per cycle and gives one result word
// per cycle. A word passes the product register, the discriminant register,
// 25 square root stages (one root bit each), a register that forms
// numerators and divisors, 35 divider stages (one quotient bit each)
// and the output register. A stall on the result side holds the whole
// pipeline. Quotients are truncated toward zero and the square root is
// floored. With Q8.8 inputs every root stays well inside the Q24.16 range,
// so overflow_flag always reads zero.
module quadratic_root_solver (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic signed [qrs_pkg::COEFF_WIDTH-1:0] coeff_a,
	input  logic signed [qrs_pkg::COEFF_WIDTH-1:0] coeff_b,
	input  logic signed [qrs_pkg::COEFF_WIDTH-1:0] coeff_c,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [qrs_pkg::CLASS_WIDTH-1:0]    root_class,
	output logic signed [qrs_pkg::ROOT_WIDTH-1:0]  root_first,
	output logic signed [qrs_pkg::ROOT_WIDTH-1:0]  root_second,
	output logic                               overflow_flag
);
	import qrs_pkg::*;
	`include "quadratic_root_solver_defines.svh"

	logic en;

	// Stage 1: coefficients and products.
	logic                      v_s1;
	logic signed [COEFF_WIDTH-1:0] a_s1, b_s1, c_s1;
	logic signed [PROD_W-1:0]  bb_s1, ac_s1;

	// Stage 2: discriminant and class.
	logic signed [DELTA_W-1:0] delta;
	logic [CLASS_WIDTH-1:0]    cls;

	// Square root pipeline.
	logic  sq_v_s [0:SQ_STAGES];
	side_t sq_sd_s [0:SQ_STAGES];
	sqrt_t sq_s [0:SQ_STAGES];

	// Numerator stage.
	logic signed [NUM_W-1:0]   n1, n2, nlin, num1, num2;
	logic signed [DSR_W:0]     den;
	side_t                     sd_last;

	// Divider pipeline.
	logic  dv_v_s [0:DIV_STAGES];
	side_t dv_sd_s [0:DIV_STAGES];
	divw_t dv1_s [0:DIV_STAGES];
	divw_t dv2_s [0:DIV_STAGES];

	// Output.
	logic signed [ROOT_WIDTH-1:0] q1, q2;
	logic                      out_valid_q;
	logic [CLASS_WIDTH-1:0]    cls_q;
	logic signed [ROOT_WIDTH-1:0] r1_q, r2_q;

	function automatic logic [NUM_W-1:0] mag_num(input logic signed [NUM_W-1:0] x);
		mag_num = x[NUM_W-1] ? NUM_W'(-x) : x;
	endfunction

	function automatic logic [DSR_W-1:0] mag_den(input logic signed [DSR_W:0] x);
		logic [DSR_W:0] m;
		m = x[DSR_W] ? (DSR_W+1)'(-x) : x;
		mag_den = m[DSR_W-1:0];
	endfunction

	// The pipeline moves whenever the output register is free or being taken.
	assign en       = !out_valid_q || !out_stall;
	assign in_stall = !en;

	// Stage 1: register the word and form b*b and a*c.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1  <= coeff_a;
			b_s1  <= coeff_b;
			c_s1  <= coeff_c;
			bb_s1 <= coeff_b * coeff_b;
			ac_s1 <= coeff_a * coeff_c;
		end
	end

	// Stage 2: exact discriminant and classification.
	always_comb begin
		delta = DELTA_W'(bb_s1) - {ac_s1, 2'b00};
		if (a_s1 == '0) begin
			cls = (b_s1 == '0) ? CLS_DEGEN : CLS_LINEAR;
		end else if (delta[DELTA_W-1]) begin
			cls = CLS_NONE;
		end else if (delta == '0) begin
			cls = CLS_DOUBLE;
		end else begin
			cls = CLS_TWO;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_v_s[0] <= 1'b0;
		end else if (en) begin
			sq_v_s[0] <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_sd_s[0].cls  <= cls;
			sq_sd_s[0].a    <= a_s1;
			sq_sd_s[0].b    <= b_s1;
			sq_sd_s[0].c    <= c_s1;
			sq_sd_s[0].neg1 <= 1'b0;
			sq_sd_s[0].neg2 <= 1'b0;
			sq_s[0].rem     <= '0;
			sq_s[0].root    <= '0;
			if (cls == CLS_TWO) begin
				sq_s[0].rad <= {1'b0, delta[DELTA_W-2:0], {RAD_SHIFT{1'b0}}};
			end else begin
				sq_s[0].rad <= '0;
			end
		end
	end

	// Square root stages with their valid bits and sideband.
	for (genvar k = 0; k < SQ_STAGES; k++) begin : g_sq
		qrs_sqrt_stage u_stage (
			.clk (clk),
			.en  (en),
			.d   (sq_s[k]),
			.q   (sq_s[k+1])
		);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_v_s[k+1] <= 1'b0;
			end else if (en) begin
				sq_v_s[k+1] <= sq_v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sq_sd_s[k+1] <= sq_sd_s[k];
			end
		end
	end

	// Numerators (-b * 2^8 +/- sqrt) * 2^8 over 2a, or -c * 2^16 over b.
	always_comb begin
		sd_last = sq_sd_s[SQ_STAGES];
		n1   = -NUM_W'($signed({sd_last.b, {(FRAC_BITS_OUT-COEFF_FRAC){1'b0}}}));
		n2   = n1 - NUM_W'({1'b0, sq_s[SQ_STAGES].root});
		n1   = n1 + NUM_W'({1'b0, sq_s[SQ_STAGES].root});
		nlin = -NUM_W'($signed({sd_last.c, {FRAC_BITS_OUT{1'b0}}}));
		if (sd_last.cls == CLS_LINEAR) begin
			num1 = nlin;
			num2 = nlin;
			den  = (DSR_W+1)'($signed(sd_last.b));
		end else begin
			num1 = {n1[NUM_W-COEFF_FRAC-1:0], {COEFF_FRAC{1'b0}}};
			num2 = {n2[NUM_W-COEFF_FRAC-1:0], {COEFF_FRAC{1'b0}}};
			den  = {sd_last.a[COEFF_WIDTH-1], sd_last.a, 1'b0};
		end
		// Quotient signs travel with the word.
		sd_last.neg1 = num1[NUM_W-1] ^ den[DSR_W];
		sd_last.neg2 = num2[NUM_W-1] ^ den[DSR_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_v_s[0] <= 1'b0;
		end else if (en) begin
			dv_v_s[0] <= sq_v_s[SQ_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_sd_s[0]      <= sd_last;
			dv1_s[0].dvd    <= mag_num(num1);
			dv1_s[0].dsr    <= mag_den(den);
			dv1_s[0].rem    <= '0;
			dv1_s[0].quo    <= '0;
			dv2_s[0].dvd    <= mag_num(num2);
			dv2_s[0].dsr    <= mag_den(den);
			dv2_s[0].rem    <= '0;
			dv2_s[0].quo    <= '0;
		end
	end

	// Divider stages, one lane per root.
	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_dv
		qrs_div_stage u_lane1 (
			.clk (clk),
			.en  (en),
			.d   (dv1_s[k]),
			.q   (dv1_s[k+1])
		);

		qrs_div_stage u_lane2 (
			.clk (clk),
			.en  (en),
			.d   (dv2_s[k]),
			.q   (dv2_s[k+1])
		);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v_s[k+1] <= 1'b0;
			end else if (en) begin
				dv_v_s[k+1] <= dv_v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dv_sd_s[k+1] <= dv_sd_s[k];
			end
		end
	end

	// Apply the quotient signs.
	always_comb begin
		q1 = ROOT_WIDTH'(dv1_s[DIV_STAGES].quo);
		q2 = ROOT_WIDTH'(dv2_s[DIV_STAGES].quo);
		if (dv_sd_s[DIV_STAGES].neg1) begin
			q1 = -q1;
		end
		if (dv_sd_s[DIV_STAGES].neg2) begin
			q2 = -q2;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= dv_v_s[DIV_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cls_q <= dv_sd_s[DIV_STAGES].cls;
			unique case (dv_sd_s[DIV_STAGES].cls)
				CLS_LINEAR: begin
					r1_q <= q1;
					r2_q <= '0;
				end
				CLS_DOUBLE, CLS_TWO: begin
					r1_q <= q1;
					r2_q <= q2;
				end
				default: begin
					r1_q <= '0;
					r2_q <= '0;
				end
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign root_class    = cls_q;
	assign root_first    = r1_q;
	assign root_second   = r2_q;
	assign overflow_flag = 1'b0;

	// Checks.
	`QRS_ASSERT_IMPL(a_absent_zero, out_valid && (root_class == CLS_NONE || root_class == CLS_DEGEN), root_first == '0 && root_second == '0)
	`QRS_ASSERT_IMPL(a_double_same, out_valid && root_class == CLS_DOUBLE, root_first == root_second)
	`QRS_ASSERT_IMPL(a_linear_one, out_valid && root_class == CLS_LINEAR, root_second == '0)
	`QRS_ASSERT_IMPL(a_sqrt_nonzero, sq_v_s[SQ_STAGES] && sq_sd_s[SQ_STAGES].cls == CLS_TWO, sq_s[SQ_STAGES].root != '0)
	`QRS_ASSERT_NEXT(a_hold_on_stall, out_valid && out_stall, dv_v_s[DIV_STAGES] == $past(dv_v_s[DIV_STAGES]))

endmodule
